>>> hdl/register_pool_allocator_with_spill_macros.svh
// Assertion macros used by the checker file of the register pool allocator.
// Depends on nothing; the including module must have i_clk and i_rst_n in scope.
`ifndef REGISTER_POOL_ALLOCATOR_WITH_SPILL_MACROS_SVH
`define REGISTER_POOL_ALLOCATOR_WITH_SPILL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("register pool allocator check failed");

// Next-cycle implication, checked outside reset.
`define RPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("register pool allocator check failed");

`endif

>>> hdl/rpa_pkg.sv
// Package of the register pool allocator: request and result types,
// opcodes, controller/datapath command and status types. Depends on nothing.
`default_nettype none

package rpa_pkg;

    localparam int NUM_REGS_DEF   = 8;
    localparam int COUNT_BITS_DEF = 8;
    // Width of the reload mask in a result.
    localparam int MASK_BITS      = 8;

    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_FREE_ALL = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] target_reg;
    } t_req;

    typedef struct packed {
        logic [2:0] granted_reg;
        logic       spilled;
        logic       reloaded;
        logic [7:0] reload_mask;
        logic       overflow;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic spill;
        logic free_one;
        logic free_all_step;
    } t_cmd;

    typedef struct packed {
        logic cur_free;
        logic last;
    } t_stat;

endpackage

`default_nettype wire

>>> hdl/rpa_ctrl.sv
// Controller of the register pool allocator: one-hot state machine that
// sequences the datapath. Depends on rpa_pkg.
`default_nettype none

module rpa_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [1:0]   i_opcode,
    input  wire rpa_pkg::t_stat i_stat,
    output rpa_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import rpa_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_SPILL = 6'b000100,
        ST_FREE  = 6'b001000,
        ST_FALL  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode)
                        OP_ALLOC:    n_state = ST_SCAN;
                        OP_FREE:     n_state = ST_FREE;
                        OP_FREE_ALL: n_state = ST_FALL;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                // A free register ends the scan at once; if the last one is busy too, fall back to a spill.
                if (i_stat.cur_free) begin
                    n_state = ST_DONE;
                end else if (i_stat.last) begin
                    n_state = ST_SPILL;
                end
            end
            ST_SPILL: begin
                o_cmd.spill = 1'b1;
                n_state     = ST_DONE;
            end
            ST_FREE: begin
                o_cmd.free_one = 1'b1;
                n_state        = ST_DONE;
            end
            ST_FALL: begin
                o_cmd.free_all_step = 1'b1;
                if (i_stat.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

`default_nettype wire

>>> hdl/rpa_dpath.sv
// Datapath of the register pool allocator: in-use bits, spill counts, scan
// index, minimum tracker and the result register. Depends on rpa_pkg.
`default_nettype none

module rpa_dpath #(
    parameter int NUM_REGS   = rpa_pkg::NUM_REGS_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rpa_pkg::t_cmd  i_cmd,
    input  wire rpa_pkg::t_req  i_req,
    output rpa_pkg::t_stat      o_stat,
    output rpa_pkg::t_rsp       o_rsp
);
    import rpa_pkg::*;

    localparam int IW = $clog2(NUM_REGS);
    // Compare width wide enough for NUM_REGS, the 3-bit target and the mask size.
    localparam int TW = (IW > 3) ? IW + 1 : 4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [NUM_REGS-1:0]   r_busy;
    logic [COUNT_BITS-1:0] r_cnt [NUM_REGS];
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_best;
    logic [COUNT_BITS-1:0] r_min;
    logic [IW-1:0]         r_tgt;
    logic                  r_tgt_ok;
    t_rsp                  r_rsp;

    logic [IW-1:0]         rd_idx;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  rd_has_spill;
    logic                  cur_free;
    logic                  in_mask;

    // One count read port, shared by the scan, the single free and free-all.
    assign rd_idx       = i_cmd.free_one ? r_tgt : r_idx;
    assign rd_cnt       = r_cnt[rd_idx];
    assign rd_has_spill = (rd_cnt != '0);
    assign cur_free     = ~r_busy[r_idx];
    assign in_mask      = (TW'(r_idx) < TW'(MASK_BITS));

    assign o_stat.cur_free = cur_free;
    assign o_stat.last     = (r_idx == IW'(NUM_REGS - 1));
    assign o_rsp           = r_rsp;

    // Pool state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cmd.scan_step && cur_free) begin
                r_busy[r_idx] <= 1'b1;
            end
            if (i_cmd.spill && (r_min != COUNT_MAX)) begin
                r_cnt[r_best] <= r_min + COUNT_BITS'(1);
            end
            if ((i_cmd.free_one && r_tgt_ok) || i_cmd.free_all_step) begin
                if (rd_has_spill) begin
                    r_cnt[rd_idx] <= rd_cnt - COUNT_BITS'(1);
                end else begin
                    r_busy[rd_idx] <= 1'b0;
                end
            end
        end
    end

    // Per-request working registers and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx    <= '0;
            r_tgt    <= IW'(i_req.target_reg);
            r_tgt_ok <= (TW'(i_req.target_reg) < TW'(NUM_REGS));
            r_rsp    <= '0;
        end
        if (i_cmd.scan_step) begin
            if (cur_free) begin
                r_rsp.granted_reg <= 3'(r_idx);
            end
            // Strict compare keeps the lowest index among equal counts.
            if ((r_idx == '0) || (rd_cnt < r_min)) begin
                r_min  <= rd_cnt;
                r_best <= r_idx;
            end
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.spill) begin
            if (r_min == COUNT_MAX) begin
                r_rsp.overflow <= 1'b1;
            end else begin
                r_rsp.granted_reg <= 3'(r_best);
                r_rsp.spilled     <= 1'b1;
            end
        end
        if (i_cmd.free_one && r_tgt_ok) begin
            r_rsp.reloaded <= rd_has_spill;
        end
        if (i_cmd.free_all_step) begin
            if (rd_has_spill && in_mask) begin
                r_rsp.reload_mask[3'(r_idx)] <= 1'b1;
            end
            r_idx <= r_idx + IW'(1);
        end
    end

endmodule

`default_nettype wire

>>> hdl/register_pool_allocator_with_spill.sv
// Top level of the register pool allocator with spill counting.
// Depends on rpa_pkg, rpa_ctrl and rpa_dpath.
//
// Usage: drive i_req and raise start; the request is taken at an edge where
// start is high and busy is low. busy stays high until the result has been
// shown. The result appears on o_rsp for exactly one cycle with o_done high;
// the receiver cannot hold it off, so it must capture it in that cycle.
// Fields that do not apply to the operation read as zero.
//
// Sequence, from the accepting edge to the cycle with o_done high:
//   allocate: a scan from register 0 that stops at the lowest free one,
//             or runs over all NUM_REGS and then spills or overflows;
//   free one register: a single free step; free all: one step per register;
//   unused opcode: straight to the result.
// busy drops in the cycle after o_done, so a new request may follow in the
// cycle after the result. The scan over the pool runs one register per cycle
// through the single count read port.
//
// Reset (i_rst_n low at a clock edge) frees every register, clears every
// spill count and returns the controller to idle; it takes effect at once.
`default_nettype none

module register_pool_allocator_with_spill #(
    parameter int NUM_REGS   = rpa_pkg::NUM_REGS_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rpa_pkg::t_req i_req,
    output logic               o_done,
    output rpa_pkg::t_rsp      o_rsp
);
    import rpa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_req.opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    rpa_dpath #(
        .NUM_REGS   (NUM_REGS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_stat  (stat),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

>>> hdl/rpa_checker.sv
// Port-level checks for the register pool allocator, bound to the top level.
// Depends on rpa_pkg and register_pool_allocator_with_spill_macros.svh.
`default_nettype none

`include "register_pool_allocator_with_spill_macros.svh"

module rpa_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_start,
    input wire logic          i_busy,
    input wire logic          i_done,
    input wire rpa_pkg::t_rsp i_rsp
);
    import rpa_pkg::*;

    // A result is only shown while a request is in flight.
    `RPA_ASSERT_NOW(a_done_while_busy, i_done, i_busy)
    // An accepted request makes the block busy in the next cycle.
    `RPA_ASSERT_NEXT(a_accept_sets_busy, i_start && !i_busy, i_busy)
    // The block is ready again right after a result.
    `RPA_ASSERT_NEXT(a_ready_after_done, i_done, !i_busy)
    // A refused allocate never also reports a spill or a grant.
    `RPA_ASSERT_NOW(a_overflow_alone, i_done && i_rsp.overflow,
        !i_rsp.spilled && (i_rsp.granted_reg == 3'd0) && !i_rsp.reloaded)

endmodule

bind register_pool_allocator_with_spill rpa_checker u_rpa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_done  (o_done),
    .i_rsp   (o_rsp)
);

`default_nettype wire

>>> tb/tb_register_pool_allocator_with_spill.sv
// Self-checking testbench of register_pool_allocator_with_spill.
// A scoreboard class predicts each result from its own copy of the pool state.
// Depends on rpa_pkg and the block itself.
`timescale 1ns / 100ps

module tb_register_pool_allocator_with_spill;
    import rpa_pkg::*;

    localparam int          REGS       = NUM_REGS_DEF;
    localparam int          COUNT_MAX  = (1 << COUNT_BITS_DEF) - 1;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam int          RANDOM_ITEMS = 1450;
    localparam int          MAX_REPORTS  = 10;

    class pool_scoreboard;
        bit                      in_use[REGS];
        bit [COUNT_BITS_DEF-1:0] spill_count[REGS];
        t_rsp                    pending_rsp[$];
        int                      fail_count;
        int                      requests;
        int                      spills;
        int                      reloads;
        int                      overflows;
        int                      full_masks;

        function new();
            int i;
            for (i = 0; i < REGS; i++) begin
                in_use[i]      = 1'b0;
                spill_count[i] = '0;
            end
            fail_count = 0;
            requests   = 0;
            spills     = 0;
            reloads    = 0;
            overflows  = 0;
            full_masks = 0;
        endfunction

        // Releasing a register first gives back one spilled value, if any.
        function bit release_reg(int r);
            if (spill_count[r] != 0) begin
                spill_count[r] = spill_count[r] - 1'b1;
                reloads++;
                return 1'b1;
            end
            in_use[r] = 1'b0;
            return 1'b0;
        endfunction

        function t_rsp apply_pool_op(t_req r);
            t_rsp o;
            int   i;
            int   best;
            bit   found;
            o     = '0;
            found = 1'b0;
            case (r.opcode)
                OP_ALLOC: begin
                    for (i = 0; i < REGS; i++) begin
                        if (!found && !in_use[i]) begin
                            in_use[i]     = 1'b1;
                            o.granted_reg = 3'(i);
                            found         = 1'b1;
                        end
                    end
                    if (!found) begin
                        best = 0;
                        for (i = 1; i < REGS; i++) begin
                            if (spill_count[i] < spill_count[best]) best = i;
                        end
                        if (spill_count[best] == COUNT_MAX) begin
                            o.overflow = 1'b1;
                            overflows++;
                        end else begin
                            spill_count[best] = spill_count[best] + 1'b1;
                            o.granted_reg     = 3'(best);
                            o.spilled         = 1'b1;
                            spills++;
                        end
                    end
                end
                OP_FREE: begin
                    o.reloaded = release_reg(int'(r.target_reg));
                end
                OP_FREE_ALL: begin
                    for (i = 0; i < REGS; i++) o.reload_mask[i] = release_reg(i);
                    if (o.reload_mask == 8'hFF) full_masks++;
                end
                default: begin
                end
            endcase
            return o;
        endfunction

        function void note_request(t_req r);
            requests++;
            pending_rsp.push_back(apply_pool_op(r));
        endfunction

        function void report_failure(string what, t_rsp exp, t_rsp got);
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: %s: expected grant=%0d spill=%0b reload=%0b mask=%02h ovf=%0b",
                         $time, what, exp.granted_reg, exp.spilled, exp.reloaded,
                         exp.reload_mask, exp.overflow);
                $display("%0t: %s: actual   grant=%0d spill=%0b reload=%0b mask=%02h ovf=%0b",
                         $time, what, got.granted_reg, got.spilled, got.reloaded,
                         got.reload_mask, got.overflow);
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp;
            if (pending_rsp.size() == 0) begin
                report_failure("result without request", '0, got);
            end else begin
                exp = pending_rsp.pop_front();
                if (got.granted_reg !== exp.granted_reg || got.spilled !== exp.spilled ||
                    got.reloaded !== exp.reloaded || got.reload_mask !== exp.reload_mask ||
                    got.overflow !== exp.overflow) begin
                    report_failure("result mismatch", exp, got);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    pool_scoreboard sb;
    bit             no_idle;

    register_pool_allocator_with_spill dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_register_pool_allocator_with_spill: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_rsp);
    end

    // Presents one request and returns once it has been taken, then idles
    // the request side now and then.
    task automatic issue(logic [1:0] op, logic [2:0] tgt);
        int gap;
        @(negedge i_clk);
        start            = 1'b1;
        i_req.opcode     = op;
        i_req.target_reg = tgt;
        do @(posedge i_clk); while (busy);
        sb.note_request(i_req);
        if (!no_idle && $urandom_range(99) < 13) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    initial begin
        int         counted;
        int         mode;
        int         pick;
        int         i;
        logic [1:0] op;

        sb      = new();
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the pool, then spill until register 0 holds two values.
        for (i = 0; i < REGS; i++) issue(OP_ALLOC, 3'(7 - i));
        repeat (REGS + 1) issue(OP_ALLOC, 3'd7);
        issue(OP_FREE, 3'd0);
        issue(OP_FREE, 3'd3);
        issue(OP_UNUSED, 3'd5);
        issue(OP_FREE_ALL, 3'd0);
        issue(OP_FREE_ALL, 3'd7);
        issue(OP_FREE, 3'd6);
        issue(OP_FREE, 3'd7);
        issue(OP_UNUSED, 3'd0);

        // Drive every spill count to saturation until allocates are refused,
        // then drain the pool completely with free-all requests.
        while (sb.overflows < 3) issue(OP_ALLOC, 3'($urandom_range(7)));
        issue(OP_FREE, 3'd0);
        issue(OP_ALLOC, 3'd0);
        issue(OP_ALLOC, 3'd0);
        repeat (COUNT_MAX + 1) issue(OP_FREE_ALL, 3'($urandom_range(7)));

        counted = 0;
        mode    = 1;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 50 == 0) mode = $urandom_range(2);
            no_idle = (counted >= 600 && counted < 900);
            pick = $urandom_range(99);
            case (mode)
                0:       op = (pick < 70) ? OP_ALLOC : (pick < 88) ? OP_FREE :
                              (pick < 95) ? OP_FREE_ALL : OP_UNUSED;
                1:       op = (pick < 45) ? OP_ALLOC : (pick < 80) ? OP_FREE :
                              (pick < 92) ? OP_FREE_ALL : OP_UNUSED;
                default: op = (pick < 25) ? OP_ALLOC : (pick < 80) ? OP_FREE :
                              (pick < 93) ? OP_FREE_ALL : OP_UNUSED;
            endcase
            issue(op, 3'($urandom_range(7)));
            if (op != OP_UNUSED) counted++;
        end

        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (REGS + 4) @(posedge i_clk);
        if (sb.pending_rsp.size() != 0) sb.fail_count++;

        $display("Ran %0d requests: %0d spills, %0d reloads, %0d refused allocates.",
                 sb.requests, sb.spills, sb.reloads, sb.overflows);
        $display("Free-all requests with every register reloading: %0d; failures: %0d.",
                 sb.full_masks, sb.fail_count);
        if (sb.fail_count == 0) begin
            $display("tb_register_pool_allocator_with_spill: clean");
        end else begin
            $display("tb_register_pool_allocator_with_spill: errors");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/rpa_pkg.sv
hdl/rpa_ctrl.sv
hdl/rpa_dpath.sv
hdl/register_pool_allocator_with_spill.sv
hdl/rpa_checker.sv
tb/tb_register_pool_allocator_with_spill.sv
